### src/perl_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the 3D gradient noise pipeline: permutation ROM,
// gradient select codes and output format. No dependencies.
package perl_pkg;

  localparam int CELL_W = 8;
  localparam int OUT_W  = 18;

  // Gradient select codes (low 4 bits of a corner hash)
  localparam logic [3:0] GRAD_U_FROM_Y  = 4'd8;   // at or above: u takes y
  localparam logic [3:0] GRAD_V_FROM_Z  = 4'd4;   // at or above: v takes z (except below)
  localparam logic [3:0] GRAD_V_X_LOW   = 4'd12;  // v takes x
  localparam logic [3:0] GRAD_V_X_HIGH  = 4'd14;  // v takes x

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage

### src/perl_fade.sv
`timescale 1ns / 1ps
// Three-stage fade curve 6t^5-15t^4+10t^3 for one axis, with the fraction
// delayed alongside. Standalone, no package needed.
module perl_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic [FRAC_BITS-1:0] t_in,
  output logic [FRAC_BITS-1:0] t_out,
  output logic [FRAC_BITS:0]   fade
);

  localparam int FB = FRAC_BITS;
  localparam logic signed [FB+5:0]   K6     = (FB+6)'(6);
  localparam logic signed [FB+5:0]   K15ONE = (FB+6)'(15) <<< FB;
  localparam logic signed [FB+5:0]   K10ONE = (FB+6)'(10) <<< FB;
  localparam logic signed [2*FB+11:0] HALF_A = (2*FB+12)'(1) <<< (FB-1);
  localparam logic [2*FB:0]           HALF_U = (2*FB+1)'(1) << (FB-1);
  localparam logic signed [2*FB+7:0]  HALF_F = (2*FB+8)'(1) <<< (FB-1);
  localparam logic signed [2*FB+7:0]  ONE_F  = (2*FB+8)'(1) <<< FB;

  // stage 1
  logic signed [FB+5:0]   t_s, a_c;
  logic signed [2*FB+11:0] ta_p;
  logic [2*FB:0]          tt_p;
  logic [FB-1:0]          t1, tt1;
  logic signed [FB+5:0]   b1;
  // stage 2
  logic [2*FB:0]          c_p;
  logic [FB-1:0]          t2, c2;
  logic signed [FB+5:0]   b2;
  // stage 3
  logic signed [2*FB+7:0] f_p;

  always_comb begin
    t_s  = $signed({6'b0, t_in});
    a_c  = t_s * K6 - K15ONE;
    ta_p = (t_s * a_c + HALF_A) >>> FB;
    tt_p = ((2*FB+1)'(t_in) * (2*FB+1)'(t_in) + HALF_U) >> FB;
    c_p  = ((2*FB+1)'(tt1) * (2*FB+1)'(t1) + HALF_U) >> FB;
    f_p  = ($signed({1'b0, c2}) * b2 + HALF_F) >>> FB;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1  <= t_in;
      tt1 <= tt_p[FB-1:0];
      b1  <= ta_p[FB+5:0] + K10ONE;
    end
    if (en[1]) begin
      t2 <= t1;
      c2 <= c_p[FB-1:0];
      b2 <= b1;
    end
    if (en[2]) begin
      t_out <= t2;
      priority if (f_p < 0) begin
        fade <= '0;
      end else if (f_p > ONE_F) begin
        fade <= ONE_F[FB:0];
      end else begin
        fade <= f_p[FB:0];
      end
    end
  end

endmodule

### src/perl_hash.sv
`timescale 1ns / 1ps
// Three-stage corner hash: permutation ROM lookups for the eight cube
// corners. Depends on perl_pkg.
module perl_hash import perl_pkg::*; (
  input  logic              clk,
  input  logic [2:0]        en,
  input  logic [CELL_W-1:0] cx,
  input  logic [CELL_W-1:0] cy,
  input  logic [CELL_W-1:0] cz,
  output logic [7:0][3:0]   corner_h   // index bits: [0] x+1, [1] y+1, [2] z+1
);

  logic [CELL_W-1:0] a1, b1, cz1;
  logic [CELL_W-1:0] aa2, ab2, ba2, bb2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1  <= PERM_ROM[cx] + cy;
      b1  <= PERM_ROM[cx + 8'd1] + cy;
      cz1 <= cz;
    end
    if (en[1]) begin
      aa2 <= PERM_ROM[a1] + cz1;
      ab2 <= PERM_ROM[a1 + 8'd1] + cz1;
      ba2 <= PERM_ROM[b1] + cz1;
      bb2 <= PERM_ROM[b1 + 8'd1] + cz1;
    end
    if (en[2]) begin
      for (int k = 0; k < 8; k++) begin
        corner_h[k] <= PERM_ROM[(k[1] ? (k[0] ? bb2 : ab2) : (k[0] ? ba2 : aa2))
                                + {7'b0, k[2]}][3:0];
      end
    end
  end

endmodule

### src/perl_blend.sv
`timescale 1ns / 1ps
// Gradients, trilinear blend (x, y, z lerp stages) and output rounding with
// saturation: five stages. Depends on perl_pkg.
module perl_blend import perl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [4:0]           en,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  input  logic [FRAC_BITS-1:0] fz,
  input  logic [FRAC_BITS:0]   fu,
  input  logic [FRAC_BITS:0]   fv,
  input  logic [FRAC_BITS:0]   fw,
  input  logic [7:0][3:0]      corner_h,
  output logic [OUT_W-1:0]     noise
);

  localparam int FB = FRAC_BITS;
  localparam int GW = FB + 3;
  localparam int CW = GW + 9;
  localparam int DSH = (FB > 16) ? FB - 16 : 0;
  localparam int USH = (FB < 16) ? 16 - FB : 0;
  localparam logic signed [GW-1:0] ONE_G = GW'(1) <<< FB;
  localparam logic signed [CW-1:0] SAT_HI = CW'(131071);
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
      input logic signed [GW-1:0] z);
    logic signed [GW-1:0] u, v;
    u = (h < GRAD_U_FROM_Y) ? x : y;
    v = (h < GRAD_V_FROM_Z) ? y : ((h == GRAD_V_X_LOW || h == GRAD_V_X_HIGH) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [GW-1:0] lerp(input logic [FB:0] w,
      input logic signed [GW-1:0] p, input logic signed [GW-1:0] q);
    logic signed [GW:0]      d;
    logic signed [GW+FB+2:0] m;
    d = {q[GW-1], q} - {p[GW-1], p};
    m = ($signed({1'b0, w}) * d + ((GW+FB+3)'(1) <<< (FB-1))) >>> FB;
    return p + m[GW-1:0];
  endfunction

  logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [GW-1:0] g4 [8];
  logic [FB:0]          u4, v4, w4, v5, w5, w6;
  logic signed [GW-1:0] l5 [4];
  logic signed [GW-1:0] l6 [2];
  logic signed [GW-1:0] l7;
  logic signed [CW-1:0] rx, rs;

  always_comb begin
    x0 = $signed(GW'(fx));
    y0 = $signed(GW'(fy));
    z0 = $signed(GW'(fz));
    x1 = x0 - ONE_G;
    y1 = y0 - ONE_G;
    z1 = z0 - ONE_G;
    rx = CW'(l7);
  end

  generate
    if (DSH > 0) begin : g_down
      assign rs = (rx + (CW'(1) <<< (DSH - 1))) >>> DSH;
    end else begin : g_up
      assign rs = rx <<< USH;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 8; k++) begin
        g4[k] <= grad(corner_h[k], k[0] ? x1 : x0, k[1] ? y1 : y0, k[2] ? z1 : z0);
      end
      u4 <= fu;
      v4 <= fv;
      w4 <= fw;
    end
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        l5[k] <= lerp(u4, g4[2*k], g4[2*k+1]);
      end
      v5 <= v4;
      w5 <= w4;
    end
    if (en[2]) begin
      l6[0] <= lerp(v5, l5[0], l5[1]);
      l6[1] <= lerp(v5, l5[2], l5[3]);
      w6    <= w5;
    end
    if (en[3]) begin
      l7 <= lerp(w6, l6[0], l6[1]);
    end
    if (en[4]) begin
      priority if (rs > SAT_HI) begin
        noise <= SAT_HI[OUT_W-1:0];
      end else if (rs < SAT_LO) begin
        noise <= SAT_LO[OUT_W-1:0];
      end else begin
        noise <= rs[OUT_W-1:0];
      end
    end
  end

endmodule

### src/perlin_noise_3d_top.sv
`timescale 1ns / 1ps
// 3D improved gradient noise, top level: stream ports, stage valids and
// stall control. Depends on perl_pkg, perl_fade, perl_hash, perl_blend.
//
// One point in, one noise value out, one request per cycle sustained while
// the output side does not stall. The pipeline has eight register stages;
// a value is valid on the output once its point has reached stage 8.
// Stages 1-3 run the fade polynomial (two multiplies side by side in the
// first stage, one in each of the other two) beside the three levels of
// permutation ROM lookups that hash the cube corners; stage 4 forms the
// eight corner gradients; stages 5-7 are the x, y and z interpolation
// steps; stage 8 rounds to Q2.16, saturates and holds the result. Each
// stage advances when it is empty or the stage after it moves, so bubbles
// close up and a stalled result does not block new points until the pipe
// is full. No state survives between points; reset only clears valids.
module perlin_noise_3d_top import perl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // noise_value[17:0], zero pad [23:18]
);

  localparam int NSTG = 8;
  localparam int FB   = FRAC_BITS;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;
  logic [31:0]     xc, yc, zc;

  logic [FB-1:0]      tx3, ty3, tz3;
  logic [FB:0]        fu3, fv3, fw3;
  logic [7:0][3:0]    corner_h;
  logic [OUT_W-1:0]   noise;

  assign xc = s_axis_tdata[31:0];
  assign yc = s_axis_tdata[63:32];
  assign zc = s_axis_tdata[95:64];

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  perl_fade #(.FRAC_BITS(FB)) u_fade_x (
    .clk(clk), .en(en[3:1]), .t_in(xc[FB-1:0]), .t_out(tx3), .fade(fu3)
  );
  perl_fade #(.FRAC_BITS(FB)) u_fade_y (
    .clk(clk), .en(en[3:1]), .t_in(yc[FB-1:0]), .t_out(ty3), .fade(fv3)
  );
  perl_fade #(.FRAC_BITS(FB)) u_fade_z (
    .clk(clk), .en(en[3:1]), .t_in(zc[FB-1:0]), .t_out(tz3), .fade(fw3)
  );

  perl_hash u_hash (
    .clk(clk), .en(en[3:1]),
    .cx(xc[FB+CELL_W-1:FB]), .cy(yc[FB+CELL_W-1:FB]), .cz(zc[FB+CELL_W-1:FB]),
    .corner_h(corner_h)
  );

  perl_blend #(.FRAC_BITS(FB)) u_blend (
    .clk(clk), .en(en[8:4]),
    .fx(tx3), .fy(ty3), .fz(tz3), .fu(fu3), .fv(fv3), .fw(fw3),
    .corner_h(corner_h), .noise(noise)
  );

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NSTG];
  assign m_axis_tdata  = {6'b0, noise};

endmodule

### src/perl_check.sv
`timescale 1ns / 1ps
// Port-level checker for the noise pipeline, bound to the top level.
// No package dependency.
module perl_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_room: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result present after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'b0)
    else $error("output pad bits set");

endmodule

bind perlin_noise_3d_top perl_check u_perl_check (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
